// ----- hw/rtl/ttip_pkg.sv -----
// Shared types, character codes and helpers for the text-to-integer parser.
package ttip_pkg;

  localparam int unsigned CharW       = 8;
  localparam int unsigned BaseW       = 6;
  localparam int unsigned ValueW      = 64;
  localparam int unsigned OffsetW     = 16;
  localparam int unsigned PhaseW      = 3;
  localparam int unsigned OffsetLimitDef = 65535;

  localparam logic [PhaseW-1:0] PhIdle   = 3'd0;
  localparam logic [PhaseW-1:0] PhWs     = 3'd1;
  localparam logic [PhaseW-1:0] PhLead   = 3'd2;
  localparam logic [PhaseW-1:0] PhZero   = 3'd3;
  localparam logic [PhaseW-1:0] PhDigits = 3'd4;

  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChLowZ  = 8'h7A;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpZ   = 8'h5A;
  localparam logic [CharW-1:0] ChLowX  = 8'h78;
  localparam logic [CharW-1:0] ChUpX   = 8'h58;
  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChCr    = 8'h0D;
  localparam logic [CharW-1:0] DigitNone = 8'hFF;

  localparam logic [BaseW-1:0] BaseAuto = 6'd0;
  localparam logic [BaseW-1:0] BaseOct  = 6'd8;
  localparam logic [BaseW-1:0] BaseDec  = 6'd10;
  localparam logic [BaseW-1:0] BaseHex  = 6'd16;

  typedef struct packed {
    logic [PhaseW-1:0]  phase;
    logic [ValueW-1:0]  acc;
    logic               neg;
    logic [BaseW-1:0]   base;
    logic [OffsetW-1:0] pos;
    logic               dcn;
  } parse_state_t;

  typedef struct packed {
    logic [ValueW-1:0]  value;
    logic               negative;
    logic               digits_seen;
    logic [OffsetW-1:0] end_offset;
  } parse_result_t;

  function automatic logic [OffsetW-1:0] count_cap(input int unsigned lim);
    count_cap = (lim < 65535) ? lim[OffsetW-1:0] : {OffsetW{1'b1}};
  endfunction

  function automatic logic is_space(input logic [CharW-1:0] c);
    is_space = (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic logic [CharW-1:0] digit_value(input logic [CharW-1:0] c);
    if (c >= ChZero && c <= ChNine) begin
      digit_value = c - ChZero;
    end else if (c >= ChLowA && c <= ChLowZ) begin
      digit_value = c - ChLowA + 8'd10;
    end else if (c >= ChUpA && c <= ChUpZ) begin
      digit_value = c - ChUpA + 8'd10;
    end else begin
      digit_value = DigitNone;
    end
  endfunction

endpackage

// ----- hw/rtl/ttip_in_if.sv -----
// Input channel: one character word with its start flag and base.
interface ttip_in_if import ttip_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             first;
  logic [BaseW-1:0] base;

  modport source (output valid, char_code, first, base, input ready);
  modport sink   (input valid, char_code, first, base, output ready);
endinterface

// ----- hw/rtl/ttip_out_if.sv -----
// Output channel: one parsed result word.
interface ttip_out_if import ttip_pkg::*;;
  logic               valid;
  logic               ready;
  logic [ValueW-1:0]  value;
  logic               negative;
  logic               digits_seen;
  logic [OffsetW-1:0] end_offset;

  modport source (output valid, value, negative, digits_seen, end_offset, input ready);
  modport sink   (input valid, value, negative, digits_seen, end_offset, output ready);
endinterface

// ----- hw/rtl/ttip_step.sv -----
// Per-character parse step: next parser state and the result on a terminator.
module ttip_step import ttip_pkg::*; #(
  parameter int unsigned OffsetLimit = OffsetLimitDef
) (
  input  parse_state_t      state_i,
  input  logic [CharW-1:0]  char_code_i,
  input  logic              first_i,
  input  logic [BaseW-1:0]  base_i,
  output parse_state_t      state_o,
  output logic              emit_o,
  output parse_result_t     result_o
);

  localparam logic [OffsetW-1:0] CountCap = count_cap(OffsetLimit);

  always_comb begin
    parse_state_t      s;
    logic              lead;
    logic              dig;
    logic              bump;
    logic [CharW-1:0]  dval;
    logic [ValueW+BaseW-1:0] prod;

    s    = state_i;
    lead = 1'b0;
    dig  = 1'b0;
    bump = 1'b0;
    emit_o = 1'b0;
    dval = digit_value(char_code_i);
    prod = '0;

    if (first_i) begin
      s.acc   = '0;
      s.neg   = 1'b0;
      s.pos   = '0;
      s.dcn   = 1'b0;
      s.base  = base_i;
      s.phase = PhWs;
    end

    unique case (s.phase)
      PhWs: begin
        if (is_space(char_code_i)) begin
          bump = 1'b1;
        end else if (char_code_i == ChPlus || char_code_i == ChMinus) begin
          if (char_code_i == ChMinus) s.neg = 1'b1;
          bump    = 1'b1;
          s.phase = PhLead;
        end else begin
          lead = 1'b1;
        end
      end
      PhLead: lead = 1'b1;
      PhZero: begin
        s.phase = PhDigits;
        if (char_code_i == ChLowX || char_code_i == ChUpX) begin
          bump   = 1'b1;
          s.base = BaseHex;
        end else begin
          if (s.base == BaseAuto) s.base = BaseOct;
          s.dcn = 1'b1;
          dig   = 1'b1;
        end
      end
      PhDigits: dig = 1'b1;
      default: ;
    endcase

    if (lead) begin
      if ((s.base == BaseAuto || s.base == BaseHex) && char_code_i == ChZero) begin
        bump    = 1'b1;
        s.phase = PhZero;
      end else begin
        if (s.base == BaseAuto) s.base = BaseDec;
        s.phase = PhDigits;
        dig     = 1'b1;
      end
    end

    if (dig) begin
      if (dval >= {{(CharW-BaseW){1'b0}}, s.base}) begin
        emit_o  = 1'b1;
        s.phase = PhIdle;
      end else begin
        prod  = s.acc * s.base;
        s.acc = prod[ValueW-1:0] + {{(ValueW-CharW){1'b0}}, dval};
        s.dcn = 1'b1;
        bump  = 1'b1;
      end
    end

    if (bump && s.pos < CountCap) s.pos = s.pos + 1'b1;

    result_o.value       = s.neg ? (~s.acc + 1'b1) : s.acc;
    result_o.negative    = s.neg;
    result_o.digits_seen = s.dcn;
    result_o.end_offset  = s.pos;
    state_o = s;
  end

endmodule

// ----- hw/rtl/text_to_integer_parser_core.sv -----
// Streaming text-to-integer parser top level: input register, step logic, result register.
//
// in_i carries one character word per handshake: char_code, a first flag that
// opens a new string and samples base (0 selects automatic base), and the base.
// Leading whitespace, one sign and (in automatic or hex base) a 0x / 0X prefix are
// taken, then digits are accumulated modulo 2^64. The first character that is not
// a digit of the base closes the string and produces one word on out_o: value
// (two's complement, negated on a minus sign), negative, digits_seen and end_offset
// (characters consumed, saturating at min(OffsetLimit, 65535)). Characters outside
// an open string are dropped. A word is accepted every cycle unless a closing
// character is held by a stalled out_o; the parser state updates once per character
// in one pass through the step logic between the input and result registers.
// A closing character passes the input register, then the result register, to out_o.
// While out_o is stalled with a result pending, characters that do not close a
// string still advance; a closing character waits in the input register and
// in_i.ready drops until the result word is taken.
// Reset clears both valid flags and returns the parser to idle.
module text_to_integer_parser_core import ttip_pkg::*; #(
  parameter int unsigned OffsetLimit = OffsetLimitDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ttip_in_if.sink     in_i,
  ttip_out_if.source  out_o
);

  logic             in_valid_q;
  logic [CharW-1:0] char_q;
  logic             first_q;
  logic [BaseW-1:0] base_q;

  parse_state_t  state_q, state_d;
  parse_result_t result_d, result_q;
  logic          emit;
  logic          advance;
  logic          out_valid_q;

  ttip_step #(
    .OffsetLimit (OffsetLimit)
  ) u_step (
    .state_i     (state_q),
    .char_code_i (char_q),
    .first_i     (first_q),
    .base_i      (base_q),
    .state_o     (state_d),
    .emit_o      (emit),
    .result_o    (result_d)
  );

  assign advance  = in_valid_q && (!emit || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      char_q  <= in_i.char_code;
      first_q <= in_i.first;
      base_q  <= in_i.base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PhIdle, acc: '0, neg: 1'b0, base: '0, pos: '0, dcn: 1'b0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.value       = result_q.value;
  assign out_o.negative    = result_q.negative;
  assign out_o.digits_seen = result_q.digits_seen;
  assign out_o.end_offset  = result_q.end_offset;

`ifndef SYNTHESIS
  a_rise_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result appeared without a character in the input register");

  a_idle_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit) |=> (state_q.phase == PhIdle))
    else $error("parser not idle after closing a string");

  a_offset_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (result_q.end_offset <= count_cap(OffsetLimit)))
    else $error("end offset beyond saturation limit");

  a_no_digits_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_q.digits_seen) |-> (result_q.value == '0))
    else $error("nonzero value without digits");
`endif

endmodule
